// ----- src/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/sefb_pkg.sv -----
// types and constants of the sensor ema filter bank
`timescale 1ns / 1ps

package sefb_pkg;

    localparam int CHAN_W    = 4;
    localparam int DATA_W    = 32;
    localparam int ALPHA_W   = 17;
    localparam int DIFF_W    = 33;
    localparam int PROD_W    = 51;
    localparam int STEP_W    = 35;
    localparam int SUM_W     = 36;
    localparam int MOD_W     = 35;
    localparam int MOD_STEPS = 10;
    localparam int FRAC_W    = 16;

    localparam int US_CHANNELS = 4;

    localparam logic [ALPHA_W-1:0] ONE_Q16         = 17'd65536;
    localparam logic [ALPHA_W-1:0] SONAR_WT_RST    = 17'd22938;
    localparam logic [ALPHA_W-1:0] INERTIAL_WT_RST = 17'd16384;

    localparam logic signed [DIFF_W-1:0] DEG180_DIFF = 33'sd11796480;
    localparam logic signed [DIFF_W-1:0] DEG360_DIFF = 33'sd23592960;

    localparam logic [MOD_W-1:0] DEG360_Q16  = 35'd23592960;
    // multiple of 360 degrees that lifts any heading sum above zero
    localparam logic [MOD_W-1:0] WRAP_OFFSET = DEG360_Q16 << (MOD_STEPS - 1);

    typedef enum logic [0:0] {
        REG_SONAR_WT    = 1'b0,
        REG_INERTIAL_WT = 1'b1
    } cfg_reg_t;

    // result carried through the write-back pipeline
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic              wr;
        logic              fv;
        logic              wrap;
        logic [MOD_W-1:0]  val;
    } res_t;

    // subtrahend of reduction step n (1 .. MOD_STEPS)
    function automatic logic [MOD_W-1:0] mod_thr(input int n);
        return DEG360_Q16 << (MOD_STEPS - n);
    endfunction

endpackage

// ----- src/sensor_ema_filter_bank_top.sv -----
// sensor ema filter bank: per-channel exponential smoothing with heading wrap
//
// channel  | direction | tdata               | tuser
// s_axis   | in        | sample_value[31:0]  | channel[3:0], sample_valid[4]
// m_axis   | out       | filtered_value[31:0]| out_channel[3:0], filtered_valid[4]
// cfg      | in        | cfg_wdata[16:0]     | cfg_index 0 sonar weight, 1 inertial weight
//
// one transaction per clock unless the interlock or m_axis back-pressure holds it
// a sample for a channel that is still in the pipeline waits until the earlier one
// has reached the output register, as the state memory is read at entry and
// written at the end of the pipeline
// reset clears the valid marks at once, there is no clearing pass
// stalls on m_axis fill empty stages first, so input keeps flowing into bubbles
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sensor_ema_filter_bank_top
    import sefb_pkg::*;
#(
    parameter int NUM_CHANNELS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [DATA_W-1:0]  s_axis_tdata,  // sample_value[31:0]
    input  logic [CHAN_W:0]    s_axis_tuser,  // channel[3:0], sample_valid[4]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [DATA_W-1:0]  m_axis_tdata,  // filtered_value[31:0]
    output logic [CHAN_W:0]    m_axis_tuser,  // out_channel[3:0], filtered_valid[4]
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [ALPHA_W-1:0] cfg_wdata
);

    localparam int ADDR_W = $clog2(NUM_CHANNELS);
    localparam logic [7:0] NUM_CH_L = 8'(NUM_CHANNELS);
    localparam logic [7:0] HEAD_CH  = 8'(NUM_CHANNELS - 1);

    // configuration
    logic [ALPHA_W-1:0] sonar_wt_reg;
    logic [ALPHA_W-1:0] inertial_wt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sonar_wt_reg    <= SONAR_WT_RST;
            inertial_wt_reg <= INERTIAL_WT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SONAR_WT:    sonar_wt_reg    <= cfg_wdata;
                REG_INERTIAL_WT: inertial_wt_reg <= cfg_wdata;
                default:         sonar_wt_reg    <= sonar_wt_reg;
            endcase
        end
    end

    // input fields
    logic [CHAN_W-1:0] in_chan;
    logic              in_sv;
    logic              in_inr;
    logic              accept;
    logic              hazard;

    assign in_chan = s_axis_tuser[CHAN_W-1:0];
    assign in_sv   = s_axis_tuser[CHAN_W];
    assign in_inr  = ({4'b0, in_chan} < NUM_CH_L);

    // pipeline registers
    logic              a_v_reg, b_v_reg, c_v_reg, d_v_reg, o_v_reg;
    logic [CHAN_W-1:0] a_chan_reg, b_chan_reg, c_chan_reg, d_chan_reg;
    logic              a_inr_reg, b_inr_reg, c_inr_reg, d_inr_reg;
    logic              a_sv_reg, b_sv_reg, c_sv_reg, d_sv_reg;
    logic              b_mark_reg, c_mark_reg, d_mark_reg;
    logic              b_head_reg, c_head_reg, d_head_reg;
    logic [DATA_W-1:0] a_sample_reg, b_sample_reg, c_sample_reg, d_sample_reg;
    logic [DATA_W-1:0] b_prev_reg, c_prev_reg, d_prev_reg;
    logic signed [DIFF_W-1:0] b_diff_reg, c_diff_reg;
    logic [ALPHA_W-1:0]       c_alpha_reg;
    logic signed [PROD_W-1:0] d_prod_reg;
    res_t              r_reg   [MOD_STEPS+1];
    logic              r_v_reg [MOD_STEPS+1];
    logic [CHAN_W-1:0] o_chan_reg;
    logic [DATA_W-1:0] o_value_reg;
    logic              o_fv_reg;

    // next values
    logic signed [DIFF_W-1:0] b_diff_next, c_diff_next;
    logic                     b_head_next;
    logic [ALPHA_W-1:0]       c_alpha_next;
    logic signed [PROD_W-1:0] d_prod_next;
    logic [STEP_W-1:0]        e_step;
    logic [SUM_W-1:0]         e_sum;
    res_t                     e_next;
    res_t                     r_next  [MOD_STEPS+1];
    logic                     r_src_v [MOD_STEPS+1];

    // stage ready chain, from the output register back to the entry stage
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;
    logic rdy_r [MOD_STEPS+1];

    always_comb
    begin
        rdy_o = !o_v_reg || m_axis_tready;
        rdy_r[MOD_STEPS] = !r_v_reg[MOD_STEPS] || rdy_o;
        for (int j = MOD_STEPS - 1; j >= 0; j--)
        begin
            rdy_r[j] = !r_v_reg[j] || rdy_r[j+1];
        end
        rdy_d = !d_v_reg || rdy_r[0];
        rdy_c = !c_v_reg || rdy_d;
        rdy_b = !b_v_reg || rdy_c;
        rdy_a = !a_v_reg || rdy_b;
    end

    // interlock: same channel anywhere between memory read and write-back
    always_comb
    begin
        hazard = (a_v_reg && a_chan_reg == in_chan)
              || (b_v_reg && b_chan_reg == in_chan)
              || (c_v_reg && c_chan_reg == in_chan)
              || (d_v_reg && d_chan_reg == in_chan);
        for (int j = 0; j <= MOD_STEPS; j++)
        begin
            hazard = hazard || (r_v_reg[j] && r_reg[j].chan == in_chan);
        end
        hazard = hazard && in_inr;
    end

    assign s_axis_tready = rdy_a && !hazard;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // state memory
    logic [DATA_W-1:0] st_rd_data;
    logic              st_rd_mark;
    logic              st_wr_en;
    logic [CHAN_W-1:0] st_wr_chan;

    assign st_wr_en   = r_v_reg[MOD_STEPS] && rdy_o && r_reg[MOD_STEPS].wr;
    assign st_wr_chan = r_reg[MOD_STEPS].chan;

    sefb_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ADDR_W       (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_inr),
        .rd_addr (ADDR_W'(in_chan)),
        .rd_data (st_rd_data),
        .rd_mark (st_rd_mark),
        .wr_en   (st_wr_en),
        .wr_addr (ADDR_W'(st_wr_chan)),
        .wr_data (r_reg[MOD_STEPS].val[DATA_W-1:0])
    );

    // datapath
    always_comb
    begin
        b_diff_next = $signed({a_sample_reg[DATA_W-1], a_sample_reg})
                    - $signed({st_rd_data[DATA_W-1], st_rd_data});
        b_head_next = ({4'b0, a_chan_reg} == HEAD_CH);

        // heading takes the shorter arc
        c_diff_next = b_diff_reg;
        if (b_head_reg && b_diff_reg > DEG180_DIFF)
        begin
            c_diff_next = b_diff_reg - DEG360_DIFF;
        end
        else if (b_head_reg && b_diff_reg < -DEG180_DIFF)
        begin
            c_diff_next = b_diff_reg + DEG360_DIFF;
        end

        if (b_chan_reg < CHAN_W'(US_CHANNELS) && !b_head_reg)
        begin
            c_alpha_next = (sonar_wt_reg > ONE_Q16) ? ONE_Q16 : sonar_wt_reg;
        end
        else
        begin
            c_alpha_next = (inertial_wt_reg > ONE_Q16) ? ONE_Q16 : inertial_wt_reg;
        end

        d_prod_next = $signed({1'b0, c_alpha_reg}) * c_diff_reg;

        // floor shift, then add to the previous value
        e_step      = d_prod_reg[PROD_W-1:FRAC_W];
        e_next.chan = d_chan_reg;
        e_next.wr   = d_inr_reg && d_sv_reg;
        e_next.fv   = d_inr_reg && (d_mark_reg || d_sv_reg);
        e_next.wrap = d_inr_reg && d_sv_reg && d_mark_reg && d_head_reg;
        e_sum = {{(SUM_W - DATA_W){d_prev_reg[DATA_W-1]}}, d_prev_reg}
              + {{(SUM_W - STEP_W){e_step[STEP_W-1]}}, e_step}
              + (e_next.wrap ? {{(SUM_W - MOD_W){1'b0}}, WRAP_OFFSET} : '0);
        priority if (!d_inr_reg)
        begin
            e_next.val = '0;
        end
        else if (!d_sv_reg)
        begin
            e_next.val = d_mark_reg ? {{(MOD_W - DATA_W){1'b0}}, d_prev_reg} : '0;
        end
        else if (!d_mark_reg)
        begin
            e_next.val = {{(MOD_W - DATA_W){1'b0}}, d_sample_reg};
        end
        else
        begin
            e_next.val = e_sum[MOD_W-1:0];
        end

        // modulo 360 degrees, one restoring step per stage
        r_next[0]  = e_next;
        r_src_v[0] = d_v_reg;
        for (int j = 1; j <= MOD_STEPS; j++)
        begin
            r_next[j]  = r_reg[j-1];
            r_src_v[j] = r_v_reg[j-1];
            if (r_reg[j-1].wrap && r_reg[j-1].val >= mod_thr(j))
            begin
                r_next[j].val = r_reg[j-1].val - mod_thr(j);
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
            for (int j = 0; j <= MOD_STEPS; j++)
            begin
                r_v_reg[j] <= 1'b0;
            end
        end
        else
        begin
            if (rdy_a)
            begin
                a_v_reg <= accept;
            end
            if (rdy_b)
            begin
                b_v_reg <= a_v_reg;
            end
            if (rdy_c)
            begin
                c_v_reg <= b_v_reg;
            end
            if (rdy_d)
            begin
                d_v_reg <= c_v_reg;
            end
            for (int j = 0; j <= MOD_STEPS; j++)
            begin
                if (rdy_r[j])
                begin
                    r_v_reg[j] <= r_src_v[j];
                end
            end
            if (rdy_o)
            begin
                o_v_reg <= r_v_reg[MOD_STEPS];
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_chan_reg   <= in_chan;
            a_inr_reg    <= in_inr;
            a_sv_reg     <= in_sv;
            a_sample_reg <= s_axis_tdata;
        end
        if (rdy_b && a_v_reg)
        begin
            b_chan_reg   <= a_chan_reg;
            b_inr_reg    <= a_inr_reg;
            b_sv_reg     <= a_sv_reg;
            b_mark_reg   <= st_rd_mark;
            b_head_reg   <= b_head_next;
            b_sample_reg <= a_sample_reg;
            b_prev_reg   <= st_rd_data;
            b_diff_reg   <= b_diff_next;
        end
        if (rdy_c && b_v_reg)
        begin
            c_chan_reg   <= b_chan_reg;
            c_inr_reg    <= b_inr_reg;
            c_sv_reg     <= b_sv_reg;
            c_mark_reg   <= b_mark_reg;
            c_head_reg   <= b_head_reg;
            c_sample_reg <= b_sample_reg;
            c_prev_reg   <= b_prev_reg;
            c_diff_reg   <= c_diff_next;
            c_alpha_reg  <= c_alpha_next;
        end
        if (rdy_d && c_v_reg)
        begin
            d_chan_reg   <= c_chan_reg;
            d_inr_reg    <= c_inr_reg;
            d_sv_reg     <= c_sv_reg;
            d_mark_reg   <= c_mark_reg;
            d_head_reg   <= c_head_reg;
            d_sample_reg <= c_sample_reg;
            d_prev_reg   <= c_prev_reg;
            d_prod_reg   <= d_prod_next;
        end
        for (int j = 0; j <= MOD_STEPS; j++)
        begin
            if (rdy_r[j] && r_src_v[j])
            begin
                r_reg[j] <= r_next[j];
            end
        end
        if (rdy_o && r_v_reg[MOD_STEPS])
        begin
            o_chan_reg  <= r_reg[MOD_STEPS].chan;
            o_value_reg <= r_reg[MOD_STEPS].val[DATA_W-1:0];
            o_fv_reg    <= r_reg[MOD_STEPS].fv;
        end
    end

    assign m_axis_tvalid = o_v_reg;
    assign m_axis_tdata  = o_value_reg;
    assign m_axis_tuser  = {o_fv_reg, o_chan_reg};

    // a channel is never read while its write-back is happening
    `ASSERT_ALWAYS(a_no_rmw_overlap, clk, rst_n,
        !(st_wr_en && accept && in_inr && st_wr_chan == in_chan),
        "read of a channel overlaps its write-back")

    // a result whose filtered_valid is clear always reports zero
    `ASSERT_IMPLIES(a_invalid_reads_zero, clk, rst_n,
        m_axis_tvalid && !m_axis_tuser[CHAN_W], m_axis_tdata == '0,
        "invalid result carries nonzero value")

    // a filtered heading leaves the reduction inside one turn
    `ASSERT_IMPLIES(a_heading_in_turn, clk, rst_n,
        r_v_reg[MOD_STEPS] && r_reg[MOD_STEPS].wrap, r_reg[MOD_STEPS].val < DEG360_Q16,
        "heading not reduced below 360 degrees")

endmodule

// ----- src/sefb_store.sv -----
// per-channel filtered value memory and valid marks
`timescale 1ns / 1ps

module sefb_store
    import sefb_pkg::*;
#(
    parameter int NUM_CHANNELS = 14,
    parameter int ADDR_W       = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    output logic              rd_mark,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0]       mem [NUM_CHANNELS];
    logic [DATA_W-1:0]       rd_data_reg;
    logic [NUM_CHANNELS-1:0] mark_reg;
    logic                    rd_mark_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid marks clear at once on reset, data of an unmarked entry is never used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg    <= '0;
            rd_mark_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                mark_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_mark_reg <= mark_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_mark = rd_mark_reg;

endmodule

// ----- tb/sv/tb_sensor_ema_filter_bank_top.sv -----
// self-checking testbench for the sensor ema filter bank top level
`timescale 1ns / 1ps

module tb_sensor_ema_filter_bank_top;
    import sefb_pkg::*;

    localparam int NCH = 14;
    localparam longint HEAD_HALF = 64'sd11796480;
    localparam longint HEAD_FULL = 64'sd23592960;

    // one channel word, used both for samples and for filtered results
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] value;
        logic              valid;
    } ch_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [DATA_W-1:0]  s_axis_tdata = '0;
    logic [CHAN_W:0]    s_axis_tuser = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [DATA_W-1:0]  m_axis_tdata;
    logic [CHAN_W:0]    m_axis_tuser;
    logic               cfg_we = 1'b0;
    cfg_reg_t           cfg_index = REG_SONAR_WT;
    logic [ALPHA_W-1:0] cfg_wdata = '0;

    // predictor state
    logic [ALPHA_W-1:0]       sonar_wt_m;
    logic [ALPHA_W-1:0]       inertial_wt_m;
    logic signed [DATA_W-1:0] filt_store [NCH];
    logic                     filt_marks [NCH];

    ch_item_t sample_q [$];
    ch_item_t filt_expect_q [$];
    ch_item_t drv_item;
    int       items_total = 0;
    int       results_seen = 0;
    int       fault_cnt = 0;
    int       src_wait = 0;
    int       sink_wait = 0;
    bit       src_calm = 1'b0;
    bit       sink_calm = 1'b1;
    logic     drv_nxt;

    sensor_ema_filter_bank_top #(
        .NUM_CHANNELS (NCH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [ALPHA_W-1:0] sat_weight(logic [ALPHA_W-1:0] a);
        return (a > ONE_Q16) ? ONE_Q16 : a;
    endfunction

    // applies one sample to the channel store and returns the reported value
    function automatic ch_item_t ema_update(ch_item_t s);
        ch_item_t r;
        longint   prev;
        longint   cur;
        longint   diff;
        longint   weight;
        longint   acc;
        r.chan = s.chan;
        r.value = '0;
        r.valid = 1'b0;
        if (s.chan >= NCH)
            return r;
        if (s.valid)
        begin
            if (!filt_marks[s.chan])
            begin
                filt_store[s.chan] = s.value;
                filt_marks[s.chan] = 1'b1;
            end
            else
            begin
                prev = filt_store[s.chan];
                cur = $signed(s.value);
                diff = cur - prev;
                weight = (s.chan < US_CHANNELS) ? sat_weight(sonar_wt_m)
                                                : sat_weight(inertial_wt_m);
                if (s.chan == NCH - 1)
                begin
                    // shortest arc, corrected once
                    if (diff > HEAD_HALF)
                        diff = diff - HEAD_FULL;
                    if (diff < -HEAD_HALF)
                        diff = diff + HEAD_FULL;
                    acc = prev + ((weight * diff) >>> 16);
                    acc = acc % HEAD_FULL;
                    if (acc < 0)
                        acc = acc + HEAD_FULL;
                end
                else
                    acc = prev + ((weight * diff) >>> 16);
                filt_store[s.chan] = acc[DATA_W-1:0];
            end
        end
        r.value = filt_store[s.chan];
        r.valid = filt_marks[s.chan];
        return r;
    endfunction

    function automatic int draw_wait(bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [DATA_W-1:0] deg(int d);
        return 32'(d * 65536);
    endfunction

    function automatic ch_item_t rand_sample();
        ch_item_t s;
        int       k;
        s.chan = ($urandom_range(0, 19) == 0) ? CHAN_W'($urandom_range(14, 15))
                                              : CHAN_W'($urandom_range(0, NCH - 1));
        s.valid = ($urandom_range(0, 6) != 0);
        k = $urandom_range(0, 9);
        if (k == 0)
            s.value = $urandom;
        else if (k == 1)
        begin
            case ($urandom_range(0, 3))
                0: s.value = 32'h7fff_ffff;
                1: s.value = 32'h8000_0000;
                2: s.value = 32'h0000_0000;
                default: s.value = 32'hffff_ffff;
            endcase
        end
        else if (s.chan == NCH - 1)
        begin
            // headings, often close to the zero crossing
            if (k == 2)
                s.value = $urandom_range(0, 131072);
            else if (k == 3)
                s.value = 32'(HEAD_FULL - 1 - $urandom_range(0, 131072));
            else
                s.value = $urandom_range(0, 32'(HEAD_FULL - 1));
        end
        else
            s.value = 32'($urandom_range(0, 26214400)) - 32'd13107200;
        return s;
    endfunction

    task automatic add_sample(int ch, logic [DATA_W-1:0] v, logic vld);
        ch_item_t s;
        s.chan = CHAN_W'(ch);
        s.value = v;
        s.valid = vld;
        sample_q.push_back(s);
        items_total++;
    endtask

    task automatic write_alpha(cfg_reg_t idx, logic [ALPHA_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SONAR_WT)
            sonar_wt_m = v;
        else
            inertial_wt_m = v;
    endtask

    task automatic drain();
        wait (results_seen == items_total);
        repeat (24) @(posedge clk);
    endtask

    task automatic run_phase(logic [ALPHA_W-1:0] us_a, logic [ALPHA_W-1:0] imu_a, int n);
        int i;
        write_alpha(REG_SONAR_WT, us_a);
        write_alpha(REG_INERTIAL_WT, imu_a);
        for (i = 0; i < n; i++)
        begin
            sample_q.push_back(rand_sample());
            items_total++;
        end
        drain();
    endtask

    // driver: presents queued samples, predicts each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            src_wait = 0;
        end
        else
        begin
            drv_nxt = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                filt_expect_q.push_back(ema_update(drv_item));
                if ($urandom_range(0, 29) == 0)
                    src_calm = !src_calm;
                src_wait = draw_wait(src_calm);
            end
            if (!drv_nxt)
            begin
                if (src_wait > 0)
                    src_wait--;
                else if (sample_q.size() > 0)
                begin
                    drv_item = sample_q.pop_front();
                    s_axis_tdata <= drv_item.value;
                    s_axis_tuser <= {drv_item.valid, drv_item.chan};
                    drv_nxt = 1'b1;
                end
            end
            s_axis_tvalid <= drv_nxt;
        end
    end

    // monitor: checks each result transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (filt_expect_q.size() == 0)
                begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("unexpected result: chan %0d value %h valid %b",
                                 m_axis_tuser[CHAN_W-1:0], m_axis_tdata,
                                 m_axis_tuser[CHAN_W]);
                end
                else if (filt_expect_q[0].chan != m_axis_tuser[CHAN_W-1:0] ||
                         filt_expect_q[0].value != m_axis_tdata ||
                         filt_expect_q[0].valid != m_axis_tuser[CHAN_W])
                begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("mismatch: exp chan %0d value %h valid %b, %s",
                                 filt_expect_q[0].chan, filt_expect_q[0].value,
                                 filt_expect_q[0].valid,
                                 $sformatf("got chan %0d value %h valid %b",
                                           m_axis_tuser[CHAN_W-1:0], m_axis_tdata,
                                           m_axis_tuser[CHAN_W]));
                    void'(filt_expect_q.pop_front());
                end
                else
                    void'(filt_expect_q.pop_front());
                if ($urandom_range(0, 29) == 0)
                    sink_calm = !sink_calm;
                sink_wait = draw_wait(sink_calm);
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int i;
        sonar_wt_m = SONAR_WT_RST;
        inertial_wt_m = INERTIAL_WT_RST;
        for (i = 0; i < NCH; i++)
        begin
            filt_store[i] = '0;
            filt_marks[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part with the reset weights
        add_sample(0, 32'h7fff_ffff, 1'b0);   // missing sample on a fresh channel
        add_sample(0, 32'h7fff_ffff, 1'b1);   // first sample taken as is
        add_sample(0, 32'h8000_0000, 1'b1);   // widest negative difference
        add_sample(0, 32'h8000_0000, 1'b0);
        add_sample(1, 32'h8000_0000, 1'b1);
        add_sample(1, 32'h7fff_ffff, 1'b1);   // widest positive difference
        add_sample(4, 32'h0000_0000, 1'b1);
        add_sample(4, 32'hffff_ffff, 1'b1);
        add_sample(12, 32'h1234_5678, 1'b1);
        add_sample(12, 32'h0000_0000, 1'b0);
        add_sample(14, 32'hffff_ffff, 1'b1);  // channels past the bank
        add_sample(15, 32'h0000_0000, 1'b0);
        add_sample(15, 32'h8000_0000, 1'b1);
        add_sample(13, deg(350), 1'b1);
        add_sample(13, deg(10), 1'b1);        // through north, lands on 355
        add_sample(13, deg(175), 1'b1);       // exactly -180, lands on 310
        add_sample(13, deg(490), 1'b1);       // exactly +180
        add_sample(13, deg(0), 1'b0);
        add_sample(13, 32'h7fff_ffff, 1'b1);  // far out of range
        add_sample(13, 32'h8000_0000, 1'b1);
        add_sample(8, 32'h0001_0000, 1'b1);
        for (i = 0; i < 120; i++)
        begin
            sample_q.push_back(rand_sample());
            items_total++;
        end
        drain();

        run_phase(17'd0, 17'd131071, 120);
        run_phase(17'd131071, 17'd0, 120);
        run_phase(17'd65536, 17'd65535, 120);
        run_phase(17'd1, 17'd65536, 120);
        run_phase(ALPHA_W'($urandom_range(0, 65536)), ALPHA_W'($urandom_range(0, 65536)), 230);

        if (fault_cnt == 0 && filt_expect_q.size() == 0)
            $display("tb_sensor_ema_filter_bank_top: clean");
        else
            $display("tb_sensor_ema_filter_bank_top: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_sensor_ema_filter_bank_top: errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/sefb_pkg.sv
src/sefb_store.sv
src/sensor_ema_filter_bank_top.sv
tb/sv/tb_sensor_ema_filter_bank_top.sv
